/* hw/rtl/bcfb_pkg.sv */
// ----------------------------------------------------------------------------
// bcfb_pkg
// Shared types, constants and helpers for the bus target failure backoff block.
// ----------------------------------------------------------------------------
package bcfb_pkg;

  // Default width of the millisecond time base.
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Field widths.
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned STATUS_W   = 8;
  localparam int unsigned BACKOFF_W  = 32;
  localparam int unsigned INIT_W     = 16;
  localparam int unsigned LIMIT_W    = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream payload widths: status then time on the input, three flags out.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX          = '1;
  localparam logic [INIT_W-1:0]  INIT_BACKOFF_RESET = 16'd500;
  localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RESET   = 4'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_BACKOFF = 1'b0,
    CFG_FAIL_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [INIT_W-1:0]  init_backoff;
    logic [LIMIT_W-1:0] fail_limit;
  } cfg_t;

  typedef struct packed {
    logic warning;
    logic online;
    logic transaction_ok;
  } result_t;

  // Grow a backoff by half of itself, truncated, saturating at all ones.
  function automatic logic [BACKOFF_W-1:0] grow_backoff(input logic [BACKOFF_W-1:0] b);
    logic [BACKOFF_W:0] sum;
    sum = {1'b0, b} + {2'b00, b[BACKOFF_W-1:1]};
    return sum[BACKOFF_W] ? {BACKOFF_W{1'b1}} : sum[BACKOFF_W-1:0];
  endfunction

endpackage

/* hw/rtl/bus_target_failure_backoff.sv */
// ----------------------------------------------------------------------------
// bus_target_failure_backoff
// Health tracker for one bus target with exponential backoff after failure.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake              Payload
//  s_axis    in   s_axis_tvalid/tready   tuser: operation
//                                        tdata: bus_status, now_ms
//  m_axis    out  m_axis_tvalid/tready   tdata: transaction_ok, online, warning
//  cfg       in   cfg_we_i               cfg_idx_i, cfg_data_i (no read-back)
//
//  One item per cycle while the output is not stalled: an input register feeds
//  the state update and result logic, which loads the output register.
//  The backoff is grown one step ahead, so each cycle carries at most one
//  deadline add (time plus backoff) and one compare.
//  Async active-low reset returns state, config and valid flags to defaults.
//  A stalled output holds its item; the input keeps accepting until both the
//  input and output registers are full.
//
module bus_target_failure_backoff import bcfb_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] bus_status, [39:8] now_ms
  input  logic                   s_axis_tuser,  // [0] operation
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] transaction_ok, [1] online,
                                                // [2] warning, [7:3] zero
);

  cfg_t cfg;

  // Input register
  logic                in_valid_q, in_valid_d;
  logic                in_op_q;
  logic [STATUS_W-1:0] in_status_q;
  logic [NOW_W-1:0]    in_now_q;

  // Output register
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t res;

  logic s_accept;
  logic advance;
  logic en;

  // Advance whenever the output slot is free or drains this cycle.
  assign advance       = !out_valid_q || m_axis_tready;
  assign en            = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (en) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: input loads on acceptance, result on advance; else hold.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q     <= s_axis_tuser;
      in_status_q <= s_axis_tdata[STATUS_W-1:0];
      in_now_q    <= s_axis_tdata[STATUS_W +: NOW_W];
    end
    if (en) begin
      out_res_q <= res;
    end
  end

  bcfb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bcfb_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg),
    .op_i     (in_op_q),
    .status_i (in_status_q),
    .now_i    (in_now_q),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-3){1'b0}},
                          out_res_q.warning, out_res_q.online, out_res_q.transaction_ok};

endmodule

/* hw/rtl/bcfb_cfg.sv */
// ----------------------------------------------------------------------------
// bcfb_cfg
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module bcfb_cfg import bcfb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT_BACKOFF: cfg_d.init_backoff = cfg_data_i[INIT_W-1:0];
        CFG_FAIL_LIMIT:   cfg_d.fail_limit   = cfg_data_i[LIMIT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_backoff <= INIT_BACKOFF_RESET;
      cfg_q.fail_limit   <= FAIL_LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/bcfb_core.sv */
// ----------------------------------------------------------------------------
// bcfb_core
// Health state of the target and the per-item result logic.
// ----------------------------------------------------------------------------
module bcfb_core import bcfb_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cfg_t                cfg_i,
  input  logic                op_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [NOW_W-1:0]    now_i,
  output result_t             res_o
);

  // Deadline is failure time plus backoff, kept wide enough to never wrap.
  localparam int unsigned SUM_W = ((TIME_WIDTH > BACKOFF_W) ? TIME_WIDTH : BACKOFF_W) + 1;

  logic                 warn_q, warn_d;
  logic                 failed_q, failed_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [BACKOFF_W-1:0] backoff_q, backoff_d;
  logic [BACKOFF_W-1:0] grown_q, grown_d;
  logic [SUM_W-1:0]     deadline_q, deadline_d;

  logic [TIME_WIDTH-1:0] now_t;
  logic [SUM_W-1:0]      now_ext;
  logic                  fail_evt;
  logic                  pass_evt;
  logic [COUNT_W-1:0]    count_inc;

  assign now_t     = TIME_WIDTH'(now_i);
  assign now_ext   = SUM_W'(now_t);
  assign fail_evt  = op_i && (status_i != '0);
  assign pass_evt  = op_i && (status_i == '0);
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

  always_comb begin
    warn_d     = warn_q;
    failed_d   = failed_q;
    count_d    = count_q;
    backoff_d  = backoff_q;
    grown_d    = grown_q;
    deadline_d = deadline_q;
    if (fail_evt) begin
      warn_d = 1'b1;
      if (failed_q) begin
        // Take the pre-grown backoff and grow once more for the next failure.
        backoff_d = grown_q;
        grown_d   = grow_backoff(grown_q);
      end else begin
        count_d  = count_inc;
        failed_d = count_inc > {1'b0, cfg_i.fail_limit};
      end
      deadline_d = now_ext + SUM_W'(backoff_d);
    end else if (pass_evt && (count_q != '0)) begin
      warn_d    = 1'b0;
      failed_d  = 1'b0;
      count_d   = '0;
      backoff_d = BACKOFF_W'(cfg_i.init_backoff);
      grown_d   = grow_backoff(BACKOFF_W'(cfg_i.init_backoff));
    end
  end

  // A failure stamped now sets a deadline at or after now, so the target is
  // offline on that item whenever it ends up failed.
  always_comb begin
    res_o.transaction_ok = pass_evt;
    res_o.warning        = warn_d | failed_d;
    res_o.online         = !failed_d || (!fail_evt && (now_ext > deadline_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q     <= 1'b0;
      failed_q   <= 1'b0;
      count_q    <= '0;
      backoff_q  <= BACKOFF_W'(INIT_BACKOFF_RESET);
      grown_q    <= grow_backoff(BACKOFF_W'(INIT_BACKOFF_RESET));
      deadline_q <= '0;
    end else if (en_i) begin
      warn_q     <= warn_d;
      failed_q   <= failed_d;
      count_q    <= count_d;
      backoff_q  <= backoff_d;
      grown_q    <= grown_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

/* hw/rtl/bcfb_checker.sv */
// ----------------------------------------------------------------------------
// bcfb_checker
// Port-level checks for the bus target failure backoff block.
// ----------------------------------------------------------------------------
module bcfb_checker import bcfb_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Input backpressure only when the output is full and stalled.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // A fresh result comes from an item accepted into the input register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result appeared without a matching item");

  // A successful transaction clears every failure mark.
  a_ok_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1] && !m_axis_tdata[2])
    else $error("success reported with warning or offline");

  // Without a warning the target cannot be failed, so it is online.
  a_online_no_warn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("offline without warning");

endmodule

bind bus_target_failure_backoff bcfb_checker u_bcfb_checker (.*);
